// ===== rtl/deq_pkg.sv =====
package deq_pkg;

   localparam int unsigned DataW = 32;

   // request opcodes
   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_REAR  = 3'd1;
   localparam logic [2:0] OP_POP_FRONT  = 3'd2;
   localparam logic [2:0] OP_POP_REAR   = 3'd3;
   localparam logic [2:0] OP_LIST       = 3'd4;

   // response status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   // actions broadcast to every cell of the row
   localparam logic [2:0] ACT_HOLD       = 3'd0;
   localparam logic [2:0] ACT_PUSH_FRONT = 3'd1;
   localparam logic [2:0] ACT_PUSH_REAR  = 3'd2;
   localparam logic [2:0] ACT_POP_FRONT  = 3'd3;
   localparam logic [2:0] ACT_POP_REAR   = 3'd4;
   localparam logic [2:0] ACT_ROTATE     = 3'd5;

   typedef logic signed [DataW-1:0] value_type;

   typedef struct packed {
      logic [2:0] act;
      value_type  data;
   } cmd_type;

endpackage

// ===== rtl/deq_cell.sv =====
// one entry of the row; the front of the queue sits in the first cell
module deq_cell (
   input  logic               clock,
   input  logic               reset,
   input  deq_pkg::cmd_type   cmd,
   input  logic               left_valid,
   input  deq_pkg::value_type left_data,
   input  logic               right_valid,
   input  deq_pkg::value_type right_data,
   input  deq_pkg::value_type head_data,
   output logic               valid,
   output deq_pkg::value_type data,
   output deq_pkg::value_type tail_data
);

   logic               valid_ff;
   logic               valid_in;
   deq_pkg::value_type data_ff;
   deq_pkg::value_type data_in;
   logic               is_tail;

   assign is_tail   = valid_ff && !right_valid;
   assign valid     = valid_ff;
   assign data      = data_ff;
   assign tail_data = is_tail ? data_ff : '0;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      unique case (cmd.act)
         deq_pkg::ACT_PUSH_FRONT: begin
            valid_in = left_valid;
            data_in  = left_data;
         end
         deq_pkg::ACT_PUSH_REAR: begin
            if (!valid_ff && left_valid) begin
               valid_in = 1'b1;
               data_in  = cmd.data;
            end
         end
         deq_pkg::ACT_POP_FRONT: begin
            valid_in = right_valid;
            data_in  = right_data;
         end
         deq_pkg::ACT_POP_REAR: begin
            if (is_tail) begin
               valid_in = 1'b0;
            end
         end
         deq_pkg::ACT_ROTATE: begin
            // head entry wraps around to the tail position
            data_in = is_tail ? head_data : right_data;
         end
         default: begin
            valid_in = valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

// ===== rtl/deq_chain.sv =====
// row of entry cells plus the tail pick-off for rear pops
module deq_chain #(
   parameter int unsigned DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  deq_pkg::cmd_type   cmd,
   output deq_pkg::value_type head_data,
   output deq_pkg::value_type tail_data
);

   logic               valid_row [DEPTH];
   deq_pkg::value_type data_row  [DEPTH];
   deq_pkg::value_type tail_row  [DEPTH];
   logic               lv_row    [DEPTH];
   deq_pkg::value_type ld_row    [DEPTH];
   logic               rv_row    [DEPTH];
   deq_pkg::value_type rd_row    [DEPTH];

   assign head_data = data_row[0];

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_first
         // front cell takes the pushed value straight from the command
         assign lv_row[g] = 1'b1;
         assign ld_row[g] = cmd.data;
      end else begin : g_inner
         assign lv_row[g] = valid_row[g-1];
         assign ld_row[g] = data_row[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
         assign rv_row[g] = 1'b0;
         assign rd_row[g] = '0;
      end else begin : g_mid
         assign rv_row[g] = valid_row[g+1];
         assign rd_row[g] = data_row[g+1];
      end

      deq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_valid  (lv_row[g]),
         .left_data   (ld_row[g]),
         .right_valid (rv_row[g]),
         .right_data  (rd_row[g]),
         .head_data   (data_row[0]),
         .valid       (valid_row[g]),
         .data        (data_row[g]),
         .tail_data   (tail_row[g])
      );
   end

   // at most one cell is the tail, so an or over the row selects it
   always_comb begin
      tail_data = '0;
      for (int i = 0; i < DEPTH; i++) begin
         tail_data = tail_data | tail_row[i];
      end
   end

endmodule

// ===== rtl/double_ended_queue_top.sv =====
// push and pop: result registered in the cycle after the item is taken; one item per cycle
//   unless the response side stalls; list on a non-empty queue: busy flag set, then first
//   entry registered, then one entry per cycle unless stalled; new items wait until all
//   count entries have gone out, as the row of cells rotates its front entry to the tail
// reset (synchronous) empties the queue and the response register; entry data is not cleared
module double_ended_queue_top #(
   parameter int unsigned DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request item
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // opcode[2:0], data_value[34:3], zero pad[39:35]
   // response item
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // result_value[31:0]
   output logic [1:0]  rsp_tuser,  // status[1:0]
   output logic        rsp_tlast   // last_result
);

   localparam int unsigned CntW = $clog2(DEPTH + 1);

   // request fields
   logic [2:0]         req_opcode;
   deq_pkg::value_type req_value;

   assign req_opcode = req_tdata[2:0];
   assign req_value  = req_tdata[34:3];

   // occupancy and list walk
   logic [CntW-1:0]    count_ff;
   logic [CntW-1:0]    count_in;
   logic               list_busy_ff;
   logic               list_busy_in;
   logic [CntW-1:0]    remain_ff;
   logic [CntW-1:0]    remain_in;

   // response register
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [1:0]         rsp_status_ff;
   logic [1:0]         rsp_status_in;
   deq_pkg::value_type rsp_value_ff;
   deq_pkg::value_type rsp_value_in;
   logic               rsp_last_ff;
   logic               rsp_last_in;

   deq_pkg::cmd_type   cmd;
   deq_pkg::value_type head_data;
   deq_pkg::value_type tail_data;

   logic               out_free;
   logic               accept;
   logic               emit;
   logic               is_empty;
   logic               is_full;

   // response register can load when empty or being drained this cycle
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !list_busy_ff && out_free;
   assign accept     = req_tvalid && req_tready;
   assign is_empty   = (count_ff == '0);
   assign is_full    = (count_ff == CntW'(DEPTH));

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      cmd.act       = deq_pkg::ACT_HOLD;
      cmd.data      = req_value;
      emit          = 1'b0;
      rsp_status_in = deq_pkg::ST_OK;
      rsp_value_in  = '0;
      rsp_last_in   = 1'b1;
      count_in      = count_ff;
      list_busy_in  = list_busy_ff;
      remain_in     = remain_ff;

      if (list_busy_ff) begin
         // list walk: send the front entry and rotate it to the tail
         if (out_free) begin
            cmd.act      = deq_pkg::ACT_ROTATE;
            emit         = 1'b1;
            rsp_value_in = head_data;
            rsp_last_in  = (remain_ff == CntW'(1));
            remain_in    = remain_ff - CntW'(1);
            list_busy_in = (remain_ff != CntW'(1));
         end
      end else if (accept) begin
         unique case (req_opcode)
            deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_REAR: begin
               emit = 1'b1;
               if (is_full) begin
                  rsp_status_in = deq_pkg::ST_FULL;
               end else begin
                  cmd.act      = (req_opcode == deq_pkg::OP_PUSH_FRONT) ?
                                 deq_pkg::ACT_PUSH_FRONT : deq_pkg::ACT_PUSH_REAR;
                  rsp_value_in = req_value;
                  count_in     = count_ff + CntW'(1);
               end
            end
            deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_REAR: begin
               emit = 1'b1;
               if (is_empty) begin
                  rsp_status_in = deq_pkg::ST_EMPTY;
               end else if (req_opcode == deq_pkg::OP_POP_FRONT) begin
                  cmd.act      = deq_pkg::ACT_POP_FRONT;
                  rsp_value_in = head_data;
                  count_in     = count_ff - CntW'(1);
               end else begin
                  cmd.act      = deq_pkg::ACT_POP_REAR;
                  rsp_value_in = tail_data;
                  count_in     = count_ff - CntW'(1);
               end
            end
            deq_pkg::OP_LIST: begin
               if (is_empty) begin
                  emit          = 1'b1;
                  rsp_status_in = deq_pkg::ST_EMPTY;
               end else begin
                  list_busy_in = 1'b1;
                  remain_in    = count_ff;
               end
            end
            default: begin
               // undefined opcode: consumed with no response
               emit = 1'b0;
            end
         endcase
      end

      rsp_valid_in = out_free ? emit : rsp_valid_ff;
   end

   deq_chain #(
      .DEPTH (DEPTH)
   ) u_chain (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .head_data (head_data),
      .tail_data (tail_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         list_busy_ff <= 1'b0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         list_busy_ff <= list_busy_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload only loads alongside a new response
   always_ff @(posedge clock) begin
      if (out_free && emit) begin
         rsp_status_ff <= rsp_status_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

endmodule

// ===== bench/double_ended_queue_checker.sv =====
module double_ended_queue_checker #(
   parameter int unsigned DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   input  logic        rsp_tlast,
   output int          errors,
   output int          expected_left
);

   typedef struct packed {
      logic [1:0]         status;
      deq_pkg::value_type value;
      logic               last;
   } deq_result_type;

   deq_result_type due_results[$];

   // shadow copy of the queue
   deq_pkg::value_type shadow_slots [DEPTH];
   int unsigned        shadow_head;
   int unsigned        shadow_tail;
   int unsigned        shadow_fill;

   int mismatch_count = 0;

   assign errors = mismatch_count;

   function automatic void queue_result(input logic [1:0] status,
                                        input deq_pkg::value_type value,
                                        input logic last);
      deq_result_type r;
      r.status = status;
      r.value  = value;
      r.last   = last;
      due_results.push_back(r);
   endfunction

   // apply one request to the shadow queue and queue up its results
   task automatic apply_deque_op(input logic [2:0] op, input deq_pkg::value_type val);
      int unsigned pos;
      int unsigned k;
      case (op)
         deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_REAR: begin
            if (shadow_fill >= DEPTH) begin
               queue_result(deq_pkg::ST_FULL, '0, 1'b1);
            end else begin
               if (op == deq_pkg::OP_PUSH_FRONT) begin
                  shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
                  shadow_slots[shadow_head] = val;
               end else begin
                  shadow_slots[shadow_tail] = val;
                  shadow_tail = (shadow_tail + 1) % DEPTH;
               end
               shadow_fill++;
               queue_result(deq_pkg::ST_OK, val, 1'b1);
            end
         end
         deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_REAR: begin
            if (shadow_fill == 0) begin
               queue_result(deq_pkg::ST_EMPTY, '0, 1'b1);
            end else begin
               if (op == deq_pkg::OP_POP_FRONT) begin
                  pos = shadow_head;
                  shadow_head = (shadow_head + 1) % DEPTH;
               end else begin
                  shadow_tail = (shadow_tail + DEPTH - 1) % DEPTH;
                  pos = shadow_tail;
               end
               shadow_fill--;
               queue_result(deq_pkg::ST_OK, shadow_slots[pos], 1'b1);
            end
         end
         deq_pkg::OP_LIST: begin
            if (shadow_fill == 0) begin
               queue_result(deq_pkg::ST_EMPTY, '0, 1'b1);
            end else begin
               pos = shadow_head;
               for (k = 0; k < shadow_fill; k++) begin
                  queue_result(deq_pkg::ST_OK, shadow_slots[pos], k + 1 == shadow_fill);
                  pos = (pos + 1) % DEPTH;
               end
            end
         end
         default: ;  // unused opcodes give nothing
      endcase
   endtask

   task automatic compare_result();
      deq_result_type want;
      if (due_results.size() == 0) begin
         mismatch_count++;
         $display("%0t: expected no item, got status %0d value %0d last %0b",
                  $time, rsp_tuser, $signed(rsp_tdata), rsp_tlast);
      end else begin
         want = due_results.pop_front();
         if (rsp_tuser !== want.status || rsp_tdata !== want.value
             || rsp_tlast !== want.last) begin
            mismatch_count++;
            $display("%0t: mismatch: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                     $time, want.status, want.value, want.last,
                     rsp_tuser, $signed(rsp_tdata), rsp_tlast);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         due_results.delete();
         shadow_head = 0;
         shadow_tail = 0;
         shadow_fill = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            apply_deque_op(req_tdata[2:0], req_tdata[34:3]);
         end
         if (rsp_tvalid && rsp_tready) begin
            compare_result();
         end
      end
      expected_left = due_results.size();
   end

endmodule

// ===== bench/tb_double_ended_queue_top.sv =====
module tb_double_ended_queue_top;

   localparam int unsigned DEPTH       = 16;
   localparam int unsigned ITEM_TARGET = 500;
   // cycles with no item moving on either side before the run is called dead
   localparam int unsigned STALL_LIMIT = 2000;
   // opcodes above OP_LIST carry no meaning and must be dropped silently
   localparam logic [2:0]  OP_LAST_CODE = 3'd7;

   // mixes of operations for the random phases
   typedef enum int {
      MIX_EVEN,
      MIX_FILL,
      MIX_DRAIN,
      MIX_WALK
   } mix_kind_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;  // opcode[2:0], data_value[34:3], zero pad[39:35]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // result_value[31:0]
   logic [1:0]  rsp_tuser;        // status[1:0]
   logic        rsp_tlast;

   int chk_errors;
   int chk_left;

   // sender and receiver run without gaps while these are set
   bit tx_steady = 1'b0;
   bit rx_steady = 1'b0;

   int unsigned quiet_cycles = 0;

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   double_ended_queue_top #(
      .DEPTH(DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   double_ended_queue_checker #(
      .DEPTH(DEPTH)
   ) checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .errors        (chk_errors),
      .expected_left (chk_left)
   );

   // watchdog: any accepted item on either side resets the count
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // result side: a fresh stall drawn at random ahead of every item, none while rx_steady is set
   initial begin
      int unsigned stall;
      wait (!reset);
      @(negedge clock);
      forever begin
         stall = rx_steady ? 0 : $urandom_range(0, 9);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   // values lean toward the extremes now and then
   function automatic deq_pkg::value_type pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [2:0] pick_op(input mix_kind_type mix);
      int unsigned push_w;
      int unsigned pop_w;
      int unsigned list_w;
      int unsigned r;
      case (mix)
         MIX_FILL:  begin push_w = 70; pop_w = 15; list_w = 10; end
         MIX_DRAIN: begin push_w = 15; pop_w = 70; list_w = 10; end
         MIX_WALK:  begin push_w = 35; pop_w = 30; list_w = 30; end
         default:   begin push_w = 40; pop_w = 40; list_w = 15; end
      endcase
      r = $urandom_range(0, 99);
      if (r < push_w) begin
         return $urandom_range(0, 1) ? deq_pkg::OP_PUSH_REAR : deq_pkg::OP_PUSH_FRONT;
      end else if (r < push_w + pop_w) begin
         return $urandom_range(0, 1) ? deq_pkg::OP_POP_REAR : deq_pkg::OP_POP_FRONT;
      end else if (r < push_w + pop_w + list_w) begin
         return deq_pkg::OP_LIST;
      end
      return 3'($urandom_range(deq_pkg::OP_LIST + 1, OP_LAST_CODE));
   endfunction

   // drive one item at the falling edge and hold it until taken;
   // valid stays high on return so a back-to-back item needs no dip
   task automatic send_request(input logic [2:0] op, input deq_pkg::value_type val);
      int unsigned gap;
      gap = tx_steady ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, val, op};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // lower valid and wait until every result has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (chk_left != 0);
   endtask

   initial begin
      int unsigned  counted;
      int unsigned  phase_len;
      int unsigned  k;
      logic [2:0]   op;
      mix_kind_type mix;

      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty queue: list and both pops
      send_request(deq_pkg::OP_LIST, pick_value());
      send_request(deq_pkg::OP_POP_FRONT, pick_value());
      send_request(deq_pkg::OP_POP_REAR, pick_value());
      // unused opcodes, nothing comes back
      for (k = deq_pkg::OP_LIST + 1; k <= OP_LAST_CODE; k++) begin
         send_request(k[2:0], $urandom);
      end
      // fill to the brim from both ends, extremes first
      for (k = 0; k < DEPTH; k++) begin
         case (k)
            0:       send_request(deq_pkg::OP_PUSH_FRONT, 32'sh8000_0000);
            1:       send_request(deq_pkg::OP_PUSH_REAR, 32'sh7fff_ffff);
            2:       send_request(deq_pkg::OP_PUSH_FRONT, '1);
            3:       send_request(deq_pkg::OP_PUSH_REAR, '0);
            default: send_request(k[0] ? deq_pkg::OP_PUSH_REAR : deq_pkg::OP_PUSH_FRONT,
                                  $urandom);
         endcase
      end
      // full queue refuses both pushes, then a full-length list
      send_request(deq_pkg::OP_PUSH_FRONT, pick_value());
      send_request(deq_pkg::OP_PUSH_REAR, pick_value());
      send_request(deq_pkg::OP_LIST, pick_value());
      send_request(deq_pkg::OP_POP_FRONT, pick_value());
      send_request(deq_pkg::OP_POP_REAR, pick_value());

      // hold off until the queue of results has fully drained
      drain_results();

      // random phases, each with its own mix and idling pattern
      counted = 0;
      while (counted < ITEM_TARGET) begin
         mix       = mix_kind_type'($urandom_range(0, 3));
         tx_steady = ($urandom_range(0, 3) == 0);
         rx_steady = ($urandom_range(0, 3) == 0);
         phase_len = $urandom_range(20, 60);
         for (k = 0; k < phase_len && counted < ITEM_TARGET; k++) begin
            op = pick_op(mix);
            send_request(op, pick_value());
            if (op <= deq_pkg::OP_LIST) begin
               counted++;
            end
         end
         if ($urandom_range(0, 2) == 0) begin
            drain_results();
         end
      end

      // wind down: nothing pending, then a short quiet spell for strays
      tx_steady = 1'b0;
      rx_steady = 1'b0;
      drain_results();
      repeat (20) @(negedge clock);
      if (chk_errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
